[design/tli_pkg.sv]
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants for the trimmed line indexer
// Operation codes, table geometry, byte constants and inter-module structs.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned MAX_ENTRIES    = 256;
  localparam int unsigned MAX_LINE_BYTES = 255;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned POS_W = 32;
  localparam int unsigned LEN_W = 8;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_END    = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  // mark progress: 0..2 bytes of the byte order mark matched, 3 = decided
  localparam logic [1:0] MARK_DONE = 2'd3;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SPC  = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;

  function automatic logic [7:0] mark_byte(logic [1:0] p);
    logic [7:0] b;
    case (p)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      2'd2:    b = 8'hBF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_trim(logic [7:0] c);
    return (c == CH_SPC) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  typedef struct packed {
    logic [POS_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } tbl_data_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    tbl_data_t        data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] dropped;
  } res_t;

endpackage

[design/tli_ifs.sv]
// ----------------------------------------------------------------------------
// tli_ifs: request and response channels of the trimmed line indexer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface tli_req_if import tli_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic [7:0] lookup_index;

  modport source (output valid, operation, data_byte, lookup_index, input ready);
  modport sink   (input valid, operation, data_byte, lookup_index, output ready);
endinterface

interface tli_rsp_if import tli_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             entry_found;
  logic [POS_W-1:0] entry_offset;
  logic [LEN_W-1:0] entry_length;
  logic [CNT_W-1:0] entry_count;
  logic [31:0]      skipped_total;
  logic             any_entries;

  modport source (output valid, entry_found, entry_offset, entry_length, entry_count,
                  skipped_total, any_entries, input ready);
  modport sink   (input valid, entry_found, entry_offset, entry_length, entry_count,
                  skipped_total, any_entries, output ready);
endinterface

[design/trimmed_line_indexer.sv]
// ----------------------------------------------------------------------------
// trimmed_line_indexer: line index builder for a byte stream
// Trims lines, skips a byte order mark and stores kept lines in a table.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transfer: start (clears the run), data byte,
//   end of file, or lookup. Start and data produce no response; end and lookup
//   each produce one response on rsp_o.
//   One request per cycle is sustained unless a response waits on a stalled
//   receiver. A response appears the cycle after its request is taken, from
//   the result register; lookup data comes from the table's registered read.
//   The table is a 256 x 40 bit memory with one write and one read port; a
//   line is written on the cycle its newline or end request is taken, so a
//   following lookup already sees it.
//   When the receiver stalls, the response holds in the result register and
//   req_i.ready drops until it is taken; with no response waiting or the
//   receiver ready, req_i.ready stays high.
//   Reset clears position, mark and line state, counts and the result valid.
//   Table contents are not cleared: only entries below the stored count are
//   ever reported, and those were written in the current run.
// ----------------------------------------------------------------------------
module trimmed_line_indexer import tli_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tli_req_if.sink   req_i,
  tli_rsp_if.source rsp_o
);

  logic      accept;
  logic      out_valid;
  res_t      res;
  tbl_wr_t   wr;
  tbl_rd_t   rd;
  tbl_data_t rdata;

  // take a request unless a response waits and the receiver is stalled
  assign req_i.ready = !out_valid || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  tli_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (req_i.operation),
    .data_byte_i    (req_i.data_byte),
    .lookup_index_i (req_i.lookup_index),
    .rsp_ready_i    (rsp_o.ready),
    .out_valid_o    (out_valid),
    .res_o          (res),
    .wr_o           (wr),
    .rd_o           (rd)
  );

  tli_table u_table (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  // table data only counts for a found lookup; the read register holds with
  // the result register since both load only on a taken request
  assign rsp_o.valid         = out_valid;
  assign rsp_o.entry_found   = res.found;
  assign rsp_o.entry_offset  = res.found ? rdata.offset : '0;
  assign rsp_o.entry_length  = res.found ? rdata.length : '0;
  assign rsp_o.entry_count   = res.count;
  assign rsp_o.skipped_total = res.dropped;
  assign rsp_o.any_entries   = (res.count != '0);

endmodule

[design/tli_table.sv]
// ----------------------------------------------------------------------------
// tli_table: line table memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module tli_table import tli_pkg::*; (
  input  logic      clk_i,
  input  tbl_wr_t   wr_i,
  input  tbl_rd_t   rd_i,
  output tbl_data_t rdata_o
);

  tbl_data_t mem [MAX_ENTRIES];
  tbl_data_t rdata_q;

  // a lookup never writes, so the same request cannot read and write one entry
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tli_scan.sv]
// ----------------------------------------------------------------------------
// tli_scan: byte scanner and line tracker
// Mark detection, trimming, line close, counters and the result register.
// ----------------------------------------------------------------------------
module tli_scan import tli_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] lookup_index_i,
  input  logic       rsp_ready_i,
  output logic       out_valid_o,
  output res_t       res_o,
  output tbl_wr_t    wr_o,
  output tbl_rd_t    rd_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       mark_q, mark_d;
  logic             inked_q, inked_d;
  logic             comment_q, comment_d;
  logic [POS_W-1:0] first_q, first_d;
  logic [POS_W-1:0] after_q, after_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      dropped_q, dropped_d;
  logic             valid_q;
  res_t             res_q;

  op_e              op;
  logic             mark_open, hit, replay;
  logic             eff_inked, eff_comment;
  logic [POS_W-1:0] eff_first, eff_after;
  logic [POS_W-1:0] line_len;
  logic             do_close, keep_line, too_long, full;
  logic             found;

  assign op        = op_e'(operation_i);
  assign mark_open = (mark_q != MARK_DONE);
  assign hit       = (op == OP_DATA) && mark_open && (data_byte_i == mark_byte(mark_q));
  // partly matched mark falls back to text: ink at 0, ends after the matched bytes
  assign replay    = mark_open && !hit && (mark_q != 2'd0) &&
                     ((op == OP_DATA) || (op == OP_END));

  assign eff_inked   = replay ? 1'b1 : inked_q;
  assign eff_comment = replay ? 1'b0 : comment_q;
  assign eff_first   = replay ? '0 : first_q;
  assign eff_after   = replay ? POS_W'(mark_q) : after_q;

  assign line_len  = eff_after - eff_first;
  assign keep_line = eff_inked && !eff_comment && (line_len != '0);
  assign too_long  = line_len > POS_W'(MAX_LINE_BYTES);
  assign full      = count_q >= CNT_W'(MAX_ENTRIES);
  assign found     = CNT_W'(lookup_index_i) < count_q;

  always_comb begin
    pos_d     = pos_q;
    mark_d    = mark_q;
    inked_d   = inked_q;
    comment_d = comment_q;
    first_d   = first_q;
    after_d   = after_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    do_close  = 1'b0;
    if (accept_i) begin
      unique case (op)
        OP_START: begin
          pos_d     = '0;
          mark_d    = '0;
          inked_d   = 1'b0;
          comment_d = 1'b0;
          first_d   = '0;
          after_d   = '0;
          count_d   = '0;
          dropped_d = '0;
        end
        OP_DATA: begin
          pos_d = pos_q + 1'b1;
          if (hit) begin
            mark_d = mark_q + 1'b1;
          end else begin
            mark_d    = MARK_DONE;
            inked_d   = eff_inked;
            comment_d = eff_comment;
            first_d   = eff_first;
            after_d   = eff_after;
            if (data_byte_i == CH_LF) begin
              do_close  = 1'b1;
              inked_d   = 1'b0;
              comment_d = 1'b0;
            end else if (!is_trim(data_byte_i)) begin
              if (!eff_inked) begin
                inked_d   = 1'b1;
                first_d   = pos_q;
                comment_d = (data_byte_i == CH_HASH);
              end
              after_d = pos_q + 1'b1;
            end
          end
        end
        OP_END: begin
          mark_d    = MARK_DONE;
          first_d   = eff_first;
          after_d   = eff_after;
          do_close  = 1'b1;
          inked_d   = 1'b0;
          comment_d = 1'b0;
        end
        OP_LOOKUP: begin
        end
        default: begin
        end
      endcase
      if (do_close && keep_line) begin
        if (too_long || full) begin
          if (dropped_q != '1) begin
            dropped_d = dropped_q + 1'b1;
          end
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    wr_o.we          = accept_i && do_close && keep_line && !too_long && !full;
    wr_o.addr        = count_q[IDX_W-1:0];
    wr_o.data.offset = eff_first;
    wr_o.data.length = line_len[LEN_W-1:0];
    rd_o.en          = accept_i && (op == OP_LOOKUP);
    rd_o.addr        = IDX_W'(lookup_index_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      mark_q    <= '0;
      inked_q   <= 1'b0;
      comment_q <= 1'b0;
      first_q   <= '0;
      after_q   <= '0;
      count_q   <= '0;
      dropped_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      mark_q    <= mark_d;
      inked_q   <= inked_d;
      comment_q <= comment_d;
      first_q   <= first_d;
      after_q   <= after_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      if (accept_i && ((op == OP_END) || (op == OP_LOOKUP))) begin
        valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept_i && ((op == OP_END) || (op == OP_LOOKUP))) begin
      res_q.found   <= (op == OP_LOOKUP) && found;
      res_q.count   <= count_d;
      res_q.dropped <= dropped_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("stored count above table depth");

  a_mark_no_ink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_open |-> !inked_q)
    else $error("line inked while mark still undecided");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (count_q < CNT_W'(MAX_ENTRIES)) && !rd_o.en)
    else $error("table write when full or during lookup");

  a_drop_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (op != OP_START)) |=> dropped_q >= $past(dropped_q))
    else $error("skipped count went down");

  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !rsp_ready_i && accept_i) |-> ((op == OP_START) || (op == OP_DATA)) ||
      !valid_q)
    else $error("result overwritten while stalled");

endmodule

[verif/tli_index_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tli_index_check: reply predictor and comparator for the trimmed line indexer
// Follows the indexer's scan state from every request taken on req_i. It
// compares each reply taken on rsp_i, field by field, with the oldest reply
// that is due.
// ----------------------------------------------------------------------------
module tli_index_check import tli_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tli_req_if          req_i,
  tli_rsp_if          rsp_i,
  output int unsigned error_count_o,
  output int unsigned replies_due_o,
  output int unsigned replies_seen_o,
  output int unsigned lines_kept_o,
  output int unsigned lines_skipped_o,
  output int unsigned lookup_hits_o
);

  // byte order mark, first byte in the low lane
  localparam logic [2:0][7:0] BOM_SEQ = {8'hBF, 8'hBB, 8'hEF};
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] count;
    logic [31:0]      skipped;
    logic             any;
  } index_reply_t;

  // scan state
  logic [POS_W-1:0] pos_q;
  logic [1:0]       bom_seen;     // 0..2 matched, MARK_DONE when decided
  logic             line_ink;
  logic             line_remark;
  logic [POS_W-1:0] ink_start;
  logic [POS_W-1:0] ink_end;
  logic [CNT_W-1:0] kept;
  logic [31:0]      skipped;
  logic [POS_W-1:0] offset_mem [MAX_ENTRIES];
  logic [LEN_W-1:0] length_mem [MAX_ENTRIES];

  index_reply_t replies_due[$];
  index_reply_t oldest;
  index_reply_t fresh;

  int unsigned n_errors = 0;
  int unsigned n_seen   = 0;
  int unsigned n_kept   = 0;
  int unsigned n_skip   = 0;
  int unsigned n_hits   = 0;
  int unsigned n_due    = 0;

  assign error_count_o   = n_errors;
  assign replies_due_o   = n_due;
  assign replies_seen_o  = n_seen;
  assign lines_kept_o    = n_kept;
  assign lines_skipped_o = n_skip;
  assign lookup_hits_o   = n_hits;

  function automatic void clear_run();
    pos_q       = '0;
    bom_seen    = '0;
    line_ink    = 1'b0;
    line_remark = 1'b0;
    ink_start   = '0;
    ink_end     = '0;
    kept        = '0;
    skipped     = '0;
  endfunction

  function automatic void close_line();
    logic [POS_W-1:0] len;
    len = ink_end - ink_start;
    if (line_ink && !line_remark && len != 0) begin
      if (len > MAX_LINE_BYTES || kept >= MAX_ENTRIES) begin
        if (skipped != '1) skipped++;
        n_skip++;
      end else begin
        offset_mem[kept[IDX_W-1:0]] = ink_start;
        length_mem[kept[IDX_W-1:0]] = len[LEN_W-1:0];
        kept++;
        n_kept++;
      end
    end
    line_ink    = 1'b0;
    line_remark = 1'b0;
  endfunction

  function automatic void take_text(logic [7:0] c, logic [POS_W-1:0] p);
    if (c == CH_LF) begin
      close_line();
    end else if (!(c == CH_SPC || c == CH_TAB || c == CH_CR)) begin
      if (!line_ink) begin
        line_ink    = 1'b1;
        ink_start   = p;
        line_remark = (c == CH_HASH);
      end
      ink_end = p + 1;
    end
  endfunction

  // a partly matched mark turns back into text from offset 0, one per matched byte
  function automatic void replay_bom();
    for (int k = 0; k < 3; k++) begin
      if (k < bom_seen) take_text(BOM_SEQ[k], POS_W'(k));
    end
    bom_seen = MARK_DONE;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_PRINTED)
        $display("%0d ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        offset_mem[k] = '0;
        length_mem[k] = '0;
      end
      replies_due.delete();
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        n_seen++;
        if (replies_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_PRINTED)
            $display("%0d ns: reply with none due, expected none, got count %0d",
                     $time, rsp_i.entry_count);
        end else begin
          oldest = replies_due.pop_front();
          check_field("entry_found", 32'(oldest.found), 32'(rsp_i.entry_found));
          check_field("entry_offset", oldest.offset, rsp_i.entry_offset);
          check_field("entry_length", 32'(oldest.length), 32'(rsp_i.entry_length));
          check_field("entry_count", 32'(oldest.count), 32'(rsp_i.entry_count));
          check_field("skipped_total", oldest.skipped, rsp_i.skipped_total);
          check_field("any_entries", 32'(oldest.any), 32'(rsp_i.any_entries));
        end
      end

      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        fresh = '0;
        case (op_e'(req_i.operation))
          OP_START: clear_run();
          OP_DATA: begin
            if (bom_seen != MARK_DONE && req_i.data_byte == BOM_SEQ[bom_seen]) begin
              bom_seen++;
            end else begin
              if (bom_seen != MARK_DONE) replay_bom();
              take_text(req_i.data_byte, pos_q);
            end
            pos_q++;
          end
          OP_END: begin
            if (bom_seen != MARK_DONE) replay_bom();
            close_line();
          end
          default: begin
            if (req_i.lookup_index < kept) begin
              fresh.found  = 1'b1;
              fresh.offset = offset_mem[req_i.lookup_index];
              fresh.length = length_mem[req_i.lookup_index];
              n_hits++;
            end
          end
        endcase
        if (req_i.operation == OP_END || req_i.operation == OP_LOOKUP) begin
          fresh.count   = kept;
          fresh.skipped = skipped;
          fresh.any     = (kept != 0);
          replies_due.push_back(fresh);
        end
      end
    end
    n_due = replies_due.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: request stimulus and verdict for the trimmed line indexer
// Feeds short hand-written files, a run that overfills the line table, a line
// just over the length limit and random files, while both channels stall
// at random. Replies are checked by tli_index_check beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import tli_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;   // long receiver stall
  localparam int unsigned FILL_LINES  = 257;   // more lines than table slots
  localparam int unsigned RAND_FILES  = 1;
  localparam int unsigned DRAIN_WAIT  = 10;    // cycles after the last reply

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;

  // Both flags are set only right after a posedge, so the receiver, which
  // looks at them on the falling edge, never races the stimulus process.
  logic gaps_on = 1'b0;   // random idle bursts on both channels
  logic hold_go = 1'b0;   // receiver: start one long stall, cleared when done

  int unsigned n_requests = 0;
  int unsigned error_count;
  int unsigned replies_due;
  int unsigned replies_seen;
  int unsigned lines_kept;
  int unsigned lines_skipped;
  int unsigned lookup_hits;

  tli_req_if req_if ();
  tli_rsp_if rsp_if ();

  trimmed_line_indexer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  tli_index_check i_index_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .error_count_o  (error_count),
    .replies_due_o  (replies_due),
    .replies_seen_o (replies_seen),
    .lines_kept_o   (lines_kept),
    .lines_skipped_o(lines_skipped),
    .lookup_hits_o  (lookup_hits)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop: the slowest legal run is well below a tenth of this.
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. Short stall bursts while
  // gaps_on is set; one long stall on request, counted here.
  // --------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rsp_if.ready <= 1'b1;
        hold_go = 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Drive one request at the falling edge, maybe after an idle burst, and
  // return at the rising edge where it is taken. Valid stays high so the
  // next request can follow back to back.
  task automatic send_req(op_e op, logic [7:0] b, logic [7:0] idx);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.data_byte    <= b;
    req_if.lookup_index <= idx;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    n_requests++;
  endtask

  // Drop valid before any pause, or the last request would be taken again.
  task automatic quiet_req();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  // unused payload fields carry random values; the block must ignore them
  task automatic send_byte(logic [7:0] b);
    send_req(OP_DATA, b, 8'($urandom));
  endtask

  task automatic send_op(op_e op);
    send_req(op, 8'($urandom), 8'($urandom));
  endtask

  task automatic look_up(logic [7:0] idx);
    send_req(OP_LOOKUP, 8'($urandom), idx);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // half the lookups land in the low slots that small files fill
  function automatic logic [7:0] pick_index();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
  endfunction

  function automatic logic [7:0] trim_byte();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0:       b = CH_SPC;
      1:       b = CH_TAB;
      default: b = CH_CR;
    endcase
    return b;
  endfunction

  // visible byte: never newline, trim or '#'; a fifth are high bytes
  function automatic logic [7:0] ink_byte();
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) begin
      b = 8'($urandom_range(128, 255));
    end else begin
      b = 8'($urandom_range(33, 126));
      if (b == CH_HASH) b = 8'h2A;
    end
    return b;
  endfunction

  task automatic random_line();
    int kind;
    int n;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      // text line, maybe blanks on both ends and now and then inside
      repeat ($urandom_range(0, 3)) send_byte(trim_byte());
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++)
        send_byte((k > 0 && $urandom_range(0, 4) == 0) ? trim_byte() : ink_byte());
      repeat ($urandom_range(0, 3)) send_byte(trim_byte());
      send_byte(CH_LF);
    end else if (kind < 14) begin
      // comment line
      repeat ($urandom_range(0, 2)) send_byte(trim_byte());
      send_byte(CH_HASH);
      repeat ($urandom_range(0, 5)) send_byte(ink_byte());
      send_byte(CH_LF);
    end else if (kind < 16) begin
      // blank line
      repeat ($urandom_range(0, 3)) send_byte(trim_byte());
      send_byte(CH_LF);
    end else if (kind == 16) begin
      // raw bytes, anything at all
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else if (kind < 19) begin
      repeat ($urandom_range(1, 3)) look_up(pick_index());
    end else begin
      // stray end or restart in the middle of a line
      send_op(($urandom_range(0, 1) == 0) ? OP_END : OP_START);
    end
  endtask

  // One file: usually a fresh start, a mark that is whole, cut short or
  // absent, a few lines, maybe an unterminated tail, then end and lookups.
  task automatic random_file(int n_lines);
    int bom_kind;
    if ($urandom_range(0, 9) != 0) send_op(OP_START);
    bom_kind = $urandom_range(0, 9);
    if (bom_kind < 7) send_byte(8'hEF);
    if (bom_kind < 6) send_byte(8'hBB);
    if (bom_kind < 5) send_byte(8'hBF);
    repeat (n_lines) random_line();
    if ($urandom_range(0, 2) == 0) send_byte(ink_byte());
    send_op(OP_END);
    repeat ($urandom_range(1, 4)) look_up(pick_index());
  endtask

  // one visible run of n bytes between blanks
  task automatic long_line(int n);
    send_byte(CH_SPC);
    repeat (n) send_byte(ink_byte());
    send_byte(CH_TAB);
    send_byte(CH_LF);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    req_if.valid        = 1'b0;
    req_if.operation    = OP_START;
    req_if.data_byte    = '0;
    req_if.lookup_index = '0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'b1;

    // Directed. Full mark, then a line with blanks inside and at its end,
    // a comment, a blank line and an unterminated last line that end flushes.
    // Lookups stay below the stored count until the table has been filled.
    send_op(OP_START);
    send_byte(8'hEF);
    send_byte(8'hBB);
    send_byte(8'hBF);
    send_text("A\tB \r\n#c\n \nz");
    send_op(OP_END);
    look_up(8'd0);
    look_up(8'd1);

    // broken mark: EF BB become text at offsets 0 and 1
    send_op(OP_START);
    send_byte(8'hEF);
    send_byte(8'hBB);
    send_byte(8'h71);
    send_op(OP_END);
    look_up(8'd0);

    // file too short for the mark: end replays what was matched
    send_op(OP_START);
    send_byte(8'hEF);
    send_op(OP_END);

    // pause until every reply is in
    quiet_req();
    wait (replies_due == 0);

    // Fill the table past its last slot so the overflow lines are skipped.
    // Every slot is written here, so from now on any index may be read.
    send_op(OP_START);
    for (int k = 0; k < FILL_LINES; k++) begin
      if (k % 16 == 0) send_byte(trim_byte());
      send_byte(ink_byte());
      send_byte(CH_LF);
    end
    send_op(OP_END);
    look_up(8'd0);
    look_up(8'd255);
    look_up(8'd128);

    // Long stall on the reply side while lookups keep coming: the result
    // register fills and the block has to hold off its request side.
    hold_go = 1'b1;
    repeat (8) look_up(pick_index());
    quiet_req();
    wait (!hold_go);
    @(posedge clk_i);

    for (int f = 0; f < RAND_FILES; f++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (f == 0) begin
        // one byte over the length limit: skipped, nothing stored
        send_op(OP_START);
        long_line(MAX_LINE_BYTES + 1);
        send_op(OP_END);
        look_up(8'd0);
        quiet_req();
        wait (replies_due == 0);
        @(posedge clk_i);
      end
      random_file($urandom_range(2, 6));
    end

    // last stretch runs without any idling
    gaps_on = 1'b0;
    random_file($urandom_range(3, 6));

    quiet_req();
    wait (replies_due == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("run: %0d requests sent, %0d replies checked, %0d mismatches",
             n_requests, replies_seen, error_count);
    $display("run: %0d lines indexed, %0d skipped as long or over capacity, %0d lookup hits",
             lines_kept, lines_skipped, lookup_hits);
    if (error_count == 0 && replies_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tli_pkg.sv
design/tli_ifs.sv
design/tli_table.sv
design/tli_scan.sv
design/trimmed_line_indexer.sv
verif/tli_index_check.sv
verif/testbench.sv
